FILE: hdl/base64_encoder_assert.svh
// assertion macros shared by the base64 encoder
`ifndef BASE64_ENCODER_ASSERT_SVH
`define BASE64_ENCODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64E_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define B64E_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/b64e_pkg.sv
// shared types, constants and the alphabet lookup of the base64 encoder
package b64e_pkg;

    localparam int unsigned CHAR_W      = 7;
    localparam int unsigned MAX_CHARS   = 4;
    localparam int unsigned IDX_W       = $clog2(MAX_CHARS);
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

    // characters produced by one request, in order
    typedef struct packed {
        logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
        logic [IDX_W-1:0]                 last_idx;
        logic                             last;
    } t_entry;

    // standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] v);
        logic [CHAR_W-1:0] w;
        w = {1'b0, v};
        priority if (v < 6'd26) begin
            return w + 7'd65;
        end else if (v < 6'd52) begin
            return w + 7'd71;
        end else if (v < 6'd62) begin
            return w - 7'd4;
        end else if (v == 6'd62) begin
            return 7'd43;
        end else begin
            return 7'd47;
        end
    endfunction

endpackage

FILE: hdl/b64e_front.sv
// front end: takes bytes, tracks the group phase and builds the character list
module b64e_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_byte,
    output logic             o_stall,
    input  logic             i_full,
    output logic             o_push,
    output b64e_pkg::t_entry o_entry
);

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase, mid_phase;
    logic [3:0] r_res, n_res, mid_res;
    logic       accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        o_entry.chars    = {b64e_pkg::MAX_CHARS{b64e_pkg::PAD_CHAR}};
        o_entry.last_idx = '0;
        o_entry.last     = i_last_byte;
        mid_res          = r_res;
        mid_phase        = r_phase;
        unique case (r_phase)
            PH_ONE: begin
                o_entry.chars[0] = b64e_pkg::sextet_char({r_res[1:0], i_data_byte[7:4]});
                mid_res          = i_data_byte[3:0];
                mid_phase        = PH_TWO;
            end
            PH_TWO: begin
                o_entry.chars[0] = b64e_pkg::sextet_char({r_res, i_data_byte[7:6]});
                o_entry.chars[1] = b64e_pkg::sextet_char(i_data_byte[5:0]);
                o_entry.last_idx = 2'd1;
                mid_res          = 4'd0;
                mid_phase        = PH_START;
            end
            default: begin
                // unused code behaves as start of group
                o_entry.chars[0] = b64e_pkg::sextet_char(i_data_byte[7:2]);
                mid_res          = {2'b00, i_data_byte[1:0]};
                mid_phase        = PH_ONE;
            end
        endcase

        n_res   = mid_res;
        n_phase = mid_phase;
        if (i_last_byte) begin
            priority if (mid_phase == PH_ONE) begin
                o_entry.chars[1] = b64e_pkg::sextet_char({mid_res[1:0], 4'b0000});
                o_entry.last_idx = 2'd3;
            end else if (mid_phase == PH_TWO) begin
                o_entry.chars[1] = b64e_pkg::sextet_char({mid_res, 2'b00});
                o_entry.last_idx = 2'd2;
            end else begin
                o_entry.last_idx = o_entry.last_idx;
            end
            n_res   = 4'd0;
            n_phase = PH_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_res   <= 4'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_res   <= n_res;
        end
    end

endmodule

FILE: hdl/b64e_queue.sv
// short first-in first-out queue of character lists between front and back
module b64e_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output b64e_pkg::t_entry o_entry
);

    b64e_pkg::t_entry                r_mem [b64e_pkg::QUEUE_DEPTH];
    logic [b64e_pkg::QUEUE_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [b64e_pkg::QUEUE_CW-1:0]   r_count, n_count;
    logic                            do_pop;

    assign o_full  = (r_count == b64e_pkg::QUEUE_CW'(b64e_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/b64e_back.sv
// back end: walks the head list one character per cycle, while the output is not stalled, into the output register
module b64e_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  b64e_pkg::t_entry              i_q_entry,
    output logic                          o_q_pop,
    output logic                          o_valid,
    output logic [b64e_pkg::CHAR_W-1:0]   o_out_char,
    output logic                          o_end_of_text,
    input  logic                          i_stall
);

    logic                          r_valid;
    logic [b64e_pkg::CHAR_W-1:0]   r_char;
    logic                          r_end;
    logic [b64e_pkg::IDX_W-1:0]    r_idx;
    logic                          out_free, emit, at_tail;

    assign out_free = !r_valid || !i_stall;
    assign emit     = out_free && i_q_valid;
    assign at_tail  = (r_idx == i_q_entry.last_idx);
    assign o_q_pop  = emit && at_tail;

    assign o_valid       = r_valid;
    assign o_out_char    = r_char;
    assign o_end_of_text = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (out_free) begin
                r_valid <= emit;
            end
            if (o_q_pop) begin
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_char <= i_q_entry.chars[r_idx];
            r_end  <= i_q_entry.last && at_tail;
        end
    end

endmodule

FILE: hdl/base64_encoder.sv
// top level of the base64 encoder: front end, request queue, character back end
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  byte in  | input     | i_valid / o_stall  | i_data_byte[7:0], i_last_byte
//  char out | output    | o_valid / i_stall  | o_out_char[6:0], o_end_of_text
//
//  one character leaves per cycle from the output register while the output is not
//  stalled; a byte yields one or two characters, a last byte up to four, so the
//  back end, not the byte intake, sets the rate over full groups
//  bytes are taken every cycle until the four-entry queue fills
//  the first character of a byte goes through the queue, then the output register
//  reset is synchronous, active low, and returns to the start of a group
//  output stall holds the output register; input stall is the queue-full flag
module base64_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic [6:0] o_out_char,
    output logic       o_end_of_text,
    input  logic       i_stall
);

`include "base64_encoder_assert.svh"

    // front to queue
    logic             push;
    b64e_pkg::t_entry push_entry;
    logic             q_full;

    // queue to back
    logic             q_valid;
    b64e_pkg::t_entry q_entry;
    logic             q_pop;

    // output classification for the checks below
    logic             out_take, out_pad, out_legal, pad_mid, pad_end;

    // front end: group phase, leftover bits, flush and padding decision
    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_stall     (o_stall),
        .i_full      (q_full),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    // decouples byte intake from character output
    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // back end: serializes each list, one character per cycle while the output is not stalled
    b64e_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .o_out_char    (o_out_char),
        .o_end_of_text (o_end_of_text),
        .i_stall       (i_stall)
    );

    assign out_take  = o_valid && !i_stall;
    assign out_pad   = (o_out_char == b64e_pkg::PAD_CHAR);
    assign out_legal = ((o_out_char >= 7'd65) && (o_out_char <= 7'd90))
                    || ((o_out_char >= 7'd97) && (o_out_char <= 7'd122))
                    || ((o_out_char >= 7'd48) && (o_out_char <= 7'd57))
                    || (o_out_char == 7'd43) || (o_out_char == 7'd47) || out_pad;
    assign pad_mid   = out_take && out_pad && !o_end_of_text;
    assign pad_end   = out_take && out_pad && o_end_of_text;

    // every character is from the alphabet or is padding
    `B64E_ASSERT_IMP(a_char_legal, o_valid, out_legal, "illegal output character")

    // padding that is not the end is followed at once by more padding
    `B64E_ASSERT_NXT(a_pad_run, pad_mid, o_valid && out_pad, "padding run broken")

    // padding that ends the text is not followed at once by more padding
    `B64E_ASSERT_NXT(a_end_after_pad, pad_end, !(o_valid && out_pad), "padding past end of text")

    // nothing appears at the output without a queued request
    `B64E_ASSERT_NXT(a_no_phantom, !q_valid && !(o_valid && i_stall), !o_valid, "character without request")

endmodule
